// File: src/kped_pkg.sv
// ----------------------------------------------------------------------------
// kped_pkg
// types and constants shared by the key press event detector modules
// ----------------------------------------------------------------------------
package kped_pkg;

    localparam int KEY_W  = 5;
    localparam int TIME_W = 31;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = 1'd1;

    localparam logic [CFG_W-1:0] CLICK_MS_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_MS_RST  = 16'd800;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_UP    = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4
    } kped_event_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_levels;
        logic [TIME_W-1:0] now_ms;
    } kped_in_t;

    typedef struct packed {
        kped_event_t      event_kind;
        logic [IDX_W-1:0] key_index;
    } kped_out_t;

    typedef struct packed {
        logic        hit;
        kped_event_t kind;
        logic        held;
        logic        armed;
    } kped_lane_t;

endpackage

// File: src/key_press_event_detector.sv
// ----------------------------------------------------------------------------
// key_press_event_detector
// scans key levels each poll and reports the first key event: down, up,
// short click or long press
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   in      | input     | in_valid / in_stall  | key_levels, now_ms
//   out     | output    | out_valid / out_stall| event_kind, key_index
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance
// every key lane and the priority pick settle in the accept cycle
// in_stall is high only while a result waits and out_stall is high
// reset clears flags and the output valid bit and loads default thresholds
// ----------------------------------------------------------------------------
module key_press_event_detector #(
    parameter int NUM_KEYS = 5
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  kped_pkg::kped_in_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output kped_pkg::kped_out_t             out_item,
    input  logic                            cfg_we,
    input  logic [kped_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kped_pkg::CFG_W-1:0]      cfg_data
);
    import kped_pkg::*;

    logic [CFG_W-1:0]    click_ms_reg;
    logic [CFG_W-1:0]    long_ms_reg;
    logic                out_valid_reg;
    kped_out_t           out_item_reg;
    logic                accept;
    logic [NUM_KEYS-1:0] grant;
    logic [NUM_KEYS-1:0] held_vec;
    logic [NUM_KEYS-1:0] armed_vec;
    kped_lane_t          lanes [NUM_KEYS];
    kped_out_t           pick;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        logic level;
        if (i < KEY_W)
        begin : g_pin
            assign level = in_item.key_levels[i];
        end
        else
        begin : g_nopin
            assign level = 1'b0;
        end

        kped_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .level    (level),
            .now_ms   (in_item.now_ms),
            .click_ms (click_ms_reg),
            .long_ms  (long_ms_reg),
            .commit   (accept && grant[i]),
            .status   (lanes[i])
        );

        assign held_vec[i]  = lanes[i].held;
        assign armed_vec[i] = lanes[i].armed;
    end

    kped_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .lanes (lanes),
        .grant (grant),
        .pick  (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_ms_reg <= CLICK_MS_RST;
            long_ms_reg  <= LONG_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLICK_MS: click_ms_reg <= cfg_data;
                CFG_LONG_MS:  long_ms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= pick;
        end
    end

    a_armed_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        (armed_vec & ~held_vec) == '0)
        else $error("key armed while not held");

    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant))
        else $error("more than one lane granted");

    a_none_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.event_kind == EV_NONE |-> out_item.key_index == '0)
        else $error("no-event item carries a key index");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && out_item_reg == $past(pick))
        else $error("accepted item did not reach the output register");

endmodule

// File: src/kped_lane.sv
// ----------------------------------------------------------------------------
// kped_lane
// per-key state and event decision; state moves only when the lane wins
// ----------------------------------------------------------------------------
module kped_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          level,
    input  logic [kped_pkg::TIME_W-1:0]   now_ms,
    input  logic [kped_pkg::CFG_W-1:0]    click_ms,
    input  logic [kped_pkg::CFG_W-1:0]    long_ms,
    input  logic                          commit,
    output kped_pkg::kped_lane_t          status
);
    import kped_pkg::*;

    logic              held_reg;
    logic              held_next;
    logic              armed_reg;
    logic              armed_next;
    logic [TIME_W-1:0] press_reg;
    logic [TIME_W-1:0] elapsed;
    logic              over_click;
    logic              over_long;
    kped_event_t       kind;

    assign elapsed    = now_ms - press_reg;
    assign over_click = elapsed > {{(TIME_W-CFG_W){1'b0}}, click_ms};
    assign over_long  = elapsed > {{(TIME_W-CFG_W){1'b0}}, long_ms};

    always_comb
    begin
        kind       = EV_NONE;
        held_next  = held_reg;
        armed_next = armed_reg;
        priority if (level && !held_reg)
        begin
            kind       = EV_DOWN;
            held_next  = 1'b1;
            armed_next = 1'b1;
        end
        else if (!level && held_reg)
        begin
            armed_next = 1'b0;
            if (armed_reg && over_click)
            begin
                kind = EV_CLICK;
            end
            else
            begin
                kind      = EV_UP;
                held_next = 1'b0;
            end
        end
        else if (armed_reg && level && over_long)
        begin
            kind       = EV_LONG;
            armed_next = 1'b0;
        end
        else
        begin
            kind = EV_NONE;
        end
    end

    assign status.hit   = (kind != EV_NONE);
    assign status.kind  = kind;
    assign status.held  = held_reg;
    assign status.armed = armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            armed_reg <= 1'b0;
        end
        else if (commit)
        begin
            held_reg  <= held_next;
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg <= '0;
        end
        else if (commit && kind == EV_DOWN)
        begin
            press_reg <= now_ms;
        end
    end

endmodule

// File: src/kped_merge.sv
// ----------------------------------------------------------------------------
// kped_merge
// lowest-index pick over the lane results
// ----------------------------------------------------------------------------
module kped_merge #(
    parameter int NUM_KEYS = 5
)
(
    input  kped_pkg::kped_lane_t  lanes [NUM_KEYS],
    output logic [NUM_KEYS-1:0]   grant,
    output kped_pkg::kped_out_t   pick
);
    import kped_pkg::*;

    always_comb
    begin
        grant           = '0;
        pick.event_kind = EV_NONE;
        pick.key_index  = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (lanes[i].hit)
            begin
                grant           = '0;
                grant[i]        = 1'b1;
                pick.event_kind = lanes[i].kind;
                pick.key_index  = IDX_W'(i);
            end
        end
    end

endmodule
